### src/sh13_pkg.sv
// sh13_pkg: shared types, constants and round functions of the siphash-1-3 byte stream block
// no dependencies; imported by every module of the block

package sh13_pkg;

	localparam logic [63:0] SIP_INIT0 = 64'h736f6d6570736575;
	localparam logic [63:0] SIP_INIT1 = 64'h646f72616e646f6d;
	localparam logic [63:0] SIP_INIT2 = 64'h6c7967656e657261;
	localparam logic [63:0] SIP_INIT3 = 64'h7465646279746573;
	localparam logic [63:0] SIP_FIN_XOR = 64'h00000000000000ff;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

	// register indexes as decoded from paddr[3]
	localparam logic REG_KEY_LOW = 1'b0;
	localparam logic REG_KEY_HIGH = 1'b1;

	typedef struct packed {
		logic [63:0] v0;
		logic [63:0] v1;
		logic [63:0] v2;
		logic [63:0] v3;
	} sh13_state_t;

	// one queue entry: an optional full word, and an optional final block
	typedef struct packed {
		logic        has_word;
		logic [63:0] word;
		logic        is_last;
		logic [63:0] blk;
	} sh13_entry_t;

	function automatic sh13_state_t sh13_init(input logic [63:0] k0, input logic [63:0] k1);
		sh13_state_t s;
		s.v0 = k0 ^ SIP_INIT0;
		s.v1 = k1 ^ SIP_INIT1;
		s.v2 = k0 ^ SIP_INIT2;
		s.v3 = k1 ^ SIP_INIT3;
		return s;
	endfunction

	// first half of a sipround: two independent adds
	function automatic sh13_state_t sh13_half_a(input sh13_state_t s);
		sh13_state_t r;
		logic [63:0] a0;
		logic [63:0] a2;
		a0 = s.v0 + s.v1;
		a2 = s.v2 + s.v3;
		r.v1 = {s.v1[50:0], s.v1[63:51]} ^ a0;
		r.v0 = {a0[31:0], a0[63:32]};
		r.v3 = {s.v3[47:0], s.v3[63:48]} ^ a2;
		r.v2 = a2;
		return r;
	endfunction

	// second half of a sipround
	function automatic sh13_state_t sh13_half_b(input sh13_state_t s);
		sh13_state_t r;
		logic [63:0] b0;
		logic [63:0] b2;
		b0 = s.v0 + s.v3;
		b2 = s.v2 + s.v1;
		r.v0 = b0;
		r.v3 = {s.v3[42:0], s.v3[63:43]} ^ b0;
		r.v1 = {s.v1[46:0], s.v1[63:47]} ^ b2;
		r.v2 = {b2[31:0], b2[63:32]};
		return r;
	endfunction

endpackage

### src/sh13_if.sv
// sh13_if: valid/ready channel interfaces for message bytes and digests
// no dependencies

interface sh13_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface sh13_hash_if;
	logic        valid;
	logic        ready;
	logic [63:0] hash_value;
	modport source (output valid, output hash_value, input ready);
	modport sink (input valid, input hash_value, output ready);
endinterface

### src/sh13_front.sv
// sh13_front: accepts message bytes, packs them into words, builds queue entries
// depends on sh13_pkg and sh13_if

module sh13_front import sh13_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               clear,
	sh13_byte_if.sink          byte_in,
	input  logic               queue_full,
	output logic               push,
	output sh13_entry_t        entry
);

	logic [63:0] pend_q;
	logic [2:0]  cnt_q;
	logic [7:0]  len_q;
	logic [63:0] pend_n;
	logic [7:0]  len_n;
	logic        take;
	logic        word_full;

	assign byte_in.ready = !queue_full;
	assign take = byte_in.valid && byte_in.ready;
	assign word_full = (cnt_q == 3'd7);
	assign len_n = len_q + 8'd1;

	always_comb begin
		pend_n = pend_q;
		pend_n[{cnt_q, 3'b000} +: 8] = byte_in.data_byte;
	end

	assign push = take && (word_full || byte_in.last_byte);
	assign entry.has_word = word_full;
	assign entry.word = pend_n;
	assign entry.is_last = byte_in.last_byte;
	assign entry.blk = {len_n, (word_full ? 56'd0 : pend_n[55:0])};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			cnt_q <= '0;
			len_q <= '0;
		end else if (clear) begin
			pend_q <= '0;
			cnt_q <= '0;
			len_q <= '0;
		end else if (take) begin
			if (byte_in.last_byte) begin
				pend_q <= '0;
				cnt_q <= '0;
				len_q <= '0;
			end else if (word_full) begin
				pend_q <= '0;
				cnt_q <= '0;
				len_q <= len_n;
			end else begin
				pend_q <= pend_n;
				cnt_q <= cnt_q + 3'd1;
				len_q <= len_n;
			end
		end
	end

endmodule

### src/sh13_queue.sv
// sh13_queue: small fifo of word/finalize entries between front and back
// depends on sh13_pkg

module sh13_queue import sh13_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  sh13_entry_t push_data,
	input  logic        pop,
	output logic        full,
	output logic        not_empty,
	output sh13_entry_t head
);

	sh13_entry_t mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   cnt_q;

	assign full = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QUEUE_AW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (QUEUE_AW+1)'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> not_empty)
		else $error("queue pop while empty");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + (QUEUE_AW+1)'(1))
		else $error("queue count did not advance on push");

endmodule

### src/sh13_back.sv
// sh13_back: sipround sequencer, half a round per cycle, and digest output register
// depends on sh13_pkg and sh13_if

module sh13_back import sh13_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        restart,
	input  logic [63:0] key_low,
	input  logic [63:0] key_high,
	input  logic        entry_valid,
	input  sh13_entry_t entry,
	output logic        pop,
	sh13_hash_if.source hash_out
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_WORD = 3'd1;
	localparam logic [2:0] ST_BLK  = 3'd2;
	localparam logic [2:0] ST_FIN  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]  state_q;
	sh13_state_t v_q;
	sh13_state_t vh;
	sh13_entry_t ent_q;
	logic        half_q;
	logic [1:0]  rnd_q;
	logic        out_valid_q;
	logic [63:0] hash_q;
	logic        out_free;

	assign vh = half_q ? sh13_half_b(v_q) : sh13_half_a(v_q);
	assign out_free = !out_valid_q || hash_out.ready;
	assign pop = (state_q == ST_IDLE) && !restart && entry_valid;

	assign hash_out.valid = out_valid_q;
	assign hash_out.hash_value = hash_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= entry;
		end
		if (state_q == ST_OUT && out_free) begin
			hash_q <= v_q.v0 ^ v_q.v1 ^ v_q.v2 ^ v_q.v3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			v_q <= sh13_init(64'd0, 64'd0);
			half_q <= 1'b0;
			rnd_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (hash_out.ready) begin
				out_valid_q <= 1'b0;
			end
			if (restart) begin
				v_q <= sh13_init(key_low, key_high);
				state_q <= ST_IDLE;
			end else begin
				case (state_q)
					ST_IDLE: begin
						if (entry_valid) begin
							half_q <= 1'b0;
							rnd_q <= '0;
							if (entry.has_word) begin
								v_q.v3 <= v_q.v3 ^ entry.word;
								state_q <= ST_WORD;
							end else begin
								v_q.v3 <= v_q.v3 ^ entry.blk;
								state_q <= ST_BLK;
							end
						end
					end
					ST_WORD: begin
						v_q <= vh;
						half_q <= !half_q;
						if (half_q) begin
							v_q.v0 <= vh.v0 ^ ent_q.word;
							if (ent_q.is_last) begin
								v_q.v3 <= vh.v3 ^ ent_q.blk;
								state_q <= ST_BLK;
							end else begin
								state_q <= ST_IDLE;
							end
						end
					end
					ST_BLK: begin
						v_q <= vh;
						half_q <= !half_q;
						if (half_q) begin
							v_q.v0 <= vh.v0 ^ ent_q.blk;
							v_q.v2 <= vh.v2 ^ SIP_FIN_XOR;
							rnd_q <= 2'd2;
							state_q <= ST_FIN;
						end
					end
					ST_FIN: begin
						v_q <= vh;
						half_q <= !half_q;
						if (half_q) begin
							if (rnd_q == 2'd0) begin
								state_q <= ST_OUT;
							end else begin
								rnd_q <= rnd_q - 2'd1;
							end
						end
					end
					ST_OUT: begin
						if (out_free) begin
							out_valid_q <= 1'b1;
							v_q <= sh13_init(key_low, key_high);
							state_q <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

endmodule

### src/siphash13_byte_stream.sv
// siphash13_byte_stream: top level, apb key registers, front, queue and round back end
// depends on sh13_pkg, sh13_if, sh13_front, sh13_queue, sh13_back
//
//  channel    dir  handshake          payload
//  byte_in    in   valid/ready        data_byte[7:0], last_byte
//  hash_out   out  valid/ready        hash_value[63:0]
//  apb        in   psel/penable       paddr[3:0], pwdata[63:0], prdata[63:0]
//
// one byte transaction per cycle at the input while the queue is not full; a full word
// takes the back end a queue pop plus one sipround as two half rounds, one 64-bit add deep
// a final byte takes the back end through absorb of the length block and three final
// rounds, each as two half rounds, then the digest register load
// the four-entry queue lets the front keep taking bytes while the back end rounds
// reset clears keys to zero and loads the hash state from the zero key at once
// a key write reloads the hash state in the cycle after it and resets the front's packing

module siphash13_byte_stream import sh13_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	sh13_byte_if.sink   byte_in,
	sh13_hash_if.source hash_out
);

	logic [63:0] key_low_q;
	logic [63:0] key_high_q;
	logic        cfg_wr;
	logic        restart_q;

	logic        q_push;
	sh13_entry_t q_push_data;
	logic        q_pop;
	logic        q_full;
	logic        q_not_empty;
	sh13_entry_t q_head;

	// apb: zero wait states, register picked by paddr[3]
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[3] == REG_KEY_HIGH) ? key_high_q : key_low_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q <= '0;
			key_high_q <= '0;
			restart_q <= 1'b0;
		end else begin
			restart_q <= cfg_wr;
			if (cfg_wr) begin
				if (paddr[3] == REG_KEY_HIGH) begin
					key_high_q <= pwdata;
				end else begin
					key_low_q <= pwdata;
				end
			end
		end
	end

	// front: byte packing, length count, entry build
	sh13_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (cfg_wr),
		.byte_in    (byte_in),
		.queue_full (q_full),
		.push       (q_push),
		.entry      (q_push_data)
	);

	// decoupling queue
	sh13_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// back: siprounds, finalization, digest register
	sh13_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.restart     (restart_q),
		.key_low     (key_low_q),
		.key_high    (key_high_q),
		.entry_valid (q_not_empty),
		.entry       (q_head),
		.pop         (q_pop),
		.hash_out    (hash_out)
	);

endmodule

### tb/siphash13_byte_stream_tb.sv
// siphash13_byte_stream_tb: self-checking testbench for the siphash-1-3 byte stream block
// predicts every digest from its own siphash-1-3 model and checks the hash channel in order
// depends on sh13_pkg and sh13_if from src, and on the block itself
`timescale 1ns / 100ps

module siphash13_byte_stream_tb import sh13_pkg::*;;

	// run bounds
	localparam int CYCLE_LIMIT = 400000;
	// settle time after the last owed digest, with margin for the back end to drain
	localparam int SETTLE_CYCLES = 64;
	localparam int MAX_REPORTS = 10;
	localparam int HOLD_OFF_CYCLES = 400;

	// key register addresses, index in paddr[3]
	localparam logic [3:0] ADDR_KEY_LOW = {REG_KEY_LOW, 3'b000};
	localparam logic [3:0] ADDR_KEY_HIGH = {REG_KEY_HIGH, 3'b000};

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	sh13_byte_if byte_ch ();
	sh13_hash_if hash_ch ();

	siphash13_byte_stream u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.byte_in  (byte_ch),
		.hash_out (hash_ch)
	);

	// predictor state: keys, the four lanes, the unfinished word and the length byte
	logic [63:0] key_k0;
	logic [63:0] key_k1;
	sh13_state_t lanes;
	logic [63:0] tail_word;
	logic [2:0]  tail_cnt;
	logic [7:0]  msg_len;

	// digests still owed by the block, oldest first
	logic [63:0] digest_q[$];
	logic [63:0] want_digest;

	int mismatches;
	int cycle_cnt;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_left;

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// watchdog, counts every cycle of the run
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d digests outstanding", cycle_cnt,
				digest_q.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// siphash-1-3 predictor
	// ------------------------------------------------------------------

	function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
		return (x << r) | (x >> (64 - r));
	endfunction

	// one full sipround over the four lanes
	function automatic sh13_state_t mix_round(input sh13_state_t s);
		s.v0 = s.v0 + s.v1;
		s.v1 = rotl(s.v1, 13) ^ s.v0;
		s.v0 = rotl(s.v0, 32);
		s.v2 = s.v2 + s.v3;
		s.v3 = rotl(s.v3, 16) ^ s.v2;
		s.v0 = s.v0 + s.v3;
		s.v3 = rotl(s.v3, 21) ^ s.v0;
		s.v2 = s.v2 + s.v1;
		s.v1 = rotl(s.v1, 17) ^ s.v2;
		s.v2 = rotl(s.v2, 32);
		return s;
	endfunction

	// compression of one 64-bit message word, siphash-1-3 has a single round here
	function automatic sh13_state_t mix_word(input sh13_state_t s, input logic [63:0] m);
		s.v3 = s.v3 ^ m;
		s = mix_round(s);
		s.v0 = s.v0 ^ m;
		return s;
	endfunction

	// fresh message: lanes from the current key, nothing buffered
	task automatic reseed_lanes();
		lanes.v0 = key_k0 ^ SIP_INIT0;
		lanes.v1 = key_k1 ^ SIP_INIT1;
		lanes.v2 = key_k0 ^ SIP_INIT2;
		lanes.v3 = key_k1 ^ SIP_INIT3;
		tail_word = '0;
		tail_cnt = 3'd0;
		msg_len = 8'd0;
	endtask

	// one accepted byte; the final byte of a message queues its digest
	task automatic take_byte(input logic [7:0] d, input logic is_final);
		logic [63:0] blk;
		sh13_state_t fin;
		tail_word = tail_word | (64'(d) << (8 * tail_cnt));
		msg_len = msg_len + 8'd1;
		if (tail_cnt == 3'd7) begin
			// little-endian word complete
			lanes = mix_word(lanes, tail_word);
			tail_word = '0;
			tail_cnt = 3'd0;
		end else begin
			tail_cnt = tail_cnt + 3'd1;
		end
		if (is_final) begin
			// length byte on top of the tail, then the three finalization rounds
			blk = {msg_len, 56'd0} | tail_word;
			fin = mix_word(lanes, blk);
			fin.v2 = fin.v2 ^ SIP_FIN_XOR;
			repeat (3) fin = mix_round(fin);
			digest_q.push_back(fin.v0 ^ fin.v1 ^ fin.v2 ^ fin.v3);
			reseed_lanes();
		end
	endtask

	// byte channel monitor: every transaction feeds the predictor
	always @(posedge clk) begin
		if (arst_n && byte_ch.valid && byte_ch.ready)
			take_byte(byte_ch.data_byte, byte_ch.last_byte);
	end

	// ------------------------------------------------------------------
	// digest checker
	// ------------------------------------------------------------------

	task automatic note_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: %s: expected %016h actual %016h", $realtime, what, want, got);
	endtask

	always @(posedge clk) begin
		if (arst_n && hash_ch.valid && hash_ch.ready) begin
			if (digest_q.size() == 0) begin
				note_mismatch("digest with nothing pending", 'x, hash_ch.hash_value);
			end else begin
				want_digest = digest_q.pop_front();
				if (hash_ch.hash_value !== want_digest)
					note_mismatch("digest mismatch", want_digest, hash_ch.hash_value);
			end
		end
	end

	// ------------------------------------------------------------------
	// receiver: random stalls, plus a long hold-off counted here
	// ------------------------------------------------------------------

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hash_ch.ready <= 1'b0;
			hold_left--;
		end else begin
			hash_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	task automatic set_idle(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			IDLE_SENDER: begin
				send_idle_pct = 60;
				recv_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct = 0;
				recv_stall_pct = 60;
			end
			IDLE_BOTH: begin
				send_idle_pct = 30;
				recv_stall_pct = 30;
			end
			default: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
		endcase
	endtask

	// one byte transaction, random idle cycles ahead of it; returns at the accepting edge
	task automatic send_byte(input logic [7:0] d, input logic is_final);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_ch.valid <= 1'b0;
			@(negedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= d;
		byte_ch.last_byte <= is_final;
		do @(posedge clk); while (!byte_ch.ready);
	endtask

	task automatic send_message(input int len);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom_range(255)), i == len - 1);
	endtask

	// quiet the byte channel, collect every owed digest, let the back end drain
	task automatic wait_idle();
		@(negedge clk);
		byte_ch.valid <= 1'b0;
		while (digest_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// apb write: setup cycle, then access cycle until pready
	task automatic apb_write(input logic [3:0] addr, input logic [63:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		// register written at this edge, and a key write restarts the message
		if (addr == ADDR_KEY_LOW)
			key_k0 = value;
		else
			key_k1 = value;
		reseed_lanes();
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic load_key(input logic [63:0] k0, input logic [63:0] k1);
		apb_write(ADDR_KEY_LOW, k0);
		apb_write(ADDR_KEY_HIGH, k1);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// zero key after reset: single-byte messages at both byte extremes,
	// a message just short of a word and one just past a word
	task automatic test_reset_key();
		set_idle(IDLE_NONE);
		send_byte(8'h00, 1'b1);
		send_byte(8'hff, 1'b1);
		for (int i = 0; i < 7; i++)
			send_byte(8'hff, i == 6);
		for (int i = 0; i < 9; i++)
			send_byte(8'(i), i == 8);
		wait_idle();
	endtask

	// all-ones key, then the counting key of the published test vectors
	task automatic test_key_values();
		load_key('1, '1);
		send_byte(8'h5a, 1'b1);
		wait_idle();
		load_key(64'h0706050403020100, 64'h0f0e0d0c0b0a0908);
		send_byte(8'h00, 1'b0);
		send_byte(8'h01, 1'b1);
		wait_idle();
	endtask

	// a key write in the middle of a message throws the partial bytes away
	task automatic test_partial_drop();
		send_byte(8'ha5, 1'b0);
		send_byte(8'h3c, 1'b0);
		send_byte(8'hc3, 1'b0);
		wait_idle();
		load_key(64'h0123456789abcdef, 64'hfedcba9876543210);
		send_byte(8'h81, 1'b1);
		wait_idle();
	endtask

	// random messages under one idle mode and one key; mostly short, now and then
	// long enough to wrap the length byte
	task automatic test_random_traffic(input idle_mode_t mode, input int nbytes,
			input logic [63:0] k0, input logic [63:0] k1, input int first_len);
		int sent;
		int len;
		load_key(k0, k1);
		set_idle(mode);
		sent = 0;
		len = first_len;
		while (sent < nbytes) begin
			if (len == 0) begin
				if ($urandom_range(15) == 0)
					len = $urandom_range(200, 300);
				else
					len = $urandom_range(1, 20);
			end
			send_message(len);
			sent += len;
			len = 0;
		end
		wait_idle();
	endtask

	// receiver held off while single-byte messages keep coming: the digest path
	// and queue fill and the byte input has to stall
	task automatic test_backpressure();
		set_idle(IDLE_NONE);
		hold_left = HOLD_OFF_CYCLES;
		for (int i = 0; i < 60; i++)
			send_byte(8'($urandom_range(255)), 1'b1);
		wait_idle();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = '0;
		byte_ch.last_byte = 1'b0;
		hash_ch.ready = 1'b0;
		mismatches = 0;
		hold_left = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		key_k0 = '0;
		key_k1 = '0;
		reseed_lanes();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_key();
		test_key_values();
		test_partial_drop();
		test_random_traffic(IDLE_NONE, 320, rand64(), rand64(), 0);
		test_random_traffic(IDLE_SENDER, 320, '1, '0, 0);
		test_random_traffic(IDLE_RECEIVER, 320, '0, '1, 0);
		test_random_traffic(IDLE_BOTH, 320, rand64(), rand64(), 260);
		test_backpressure();

		wait_idle();
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
